// ===== rtl/core/fplw_pkg.sv =====
package fplw_pkg;

  localparam int PHYS_ADDR_BITS = 52;
  localparam int PA_W = 52;
  localparam int VA_W = 48;
  localparam int ENTRY_W = 64;
  localparam int LVL_W = 3;

  localparam logic [PA_W-1:0] PA_MASK = (PA_W'(1) << PHYS_ADDR_BITS) - PA_W'(1);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;
  localparam logic RK_READ    = 1'b0;
  localparam logic RK_DONE    = 1'b1;

  localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_TOP  = 3'd1;
  localparam logic [LVL_W-1:0] LVL_MID  = 3'd2;
  localparam logic [LVL_W-1:0] LVL_DIR  = 3'd3;
  localparam logic [LVL_W-1:0] LVL_LEAF = 3'd4;

  localparam int BIT_P = 0;
  localparam int BIT_W = 1;
  localparam int BIT_U = 2;
  localparam int BIT_H = 7;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [VA_W-1:0]  virt;
    logic             write_req;
    logic             user_check;
  } walk_state_t;

  typedef struct packed {
    logic             result_kind;
    logic [PA_W-1:0]  read_addr;
    logic [PA_W-1:0]  phys_addr;
    logic             granted;
    logic [LVL_W-1:0] stop_level;
    logic             sequence_error;
  } result_t;

endpackage

// ===== rtl/core/fplw_step.sv =====
module fplw_step (
  input  fplw_pkg::walk_state_t           cur,
  input  logic [fplw_pkg::PA_W-1:0]       root_table_base,
  input  logic                            kind,
  input  logic [fplw_pkg::VA_W-1:0]       virt_addr,
  input  logic                            write_req,
  input  logic                            user_check,
  input  logic [fplw_pkg::ENTRY_W-1:0]    entry_data,
  output fplw_pkg::walk_state_t           nxt,
  output fplw_pkg::result_t               res
);
  import fplw_pkg::*;

  // nine-bit table index of a level, top level uses the highest bits
  function automatic logic [8:0] level_index(input logic [LVL_W-1:0] lvl,
                                             input logic [VA_W-1:0] va);
    logic [8:0] idx;
    case (lvl)
      LVL_MID:  idx = va[38:30];
      LVL_DIR:  idx = va[29:21];
      LVL_LEAF: idx = va[20:12];
      default:  idx = va[47:39];
    endcase
    return idx;
  endfunction

  logic             present_ok;
  logic             is_leaf;
  logic             write_denied;
  logic [LVL_W-1:0] lvl_inc;
  logic [PA_W-1:0]  pa_huge;
  logic [PA_W-1:0]  pa_page;

  assign present_ok   = entry_data[BIT_P] && !(cur.user_check && !entry_data[BIT_U]);
  assign is_leaf      = (cur.level == LVL_LEAF) ||
                        ((cur.level == LVL_DIR) && entry_data[BIT_H]);
  assign write_denied = cur.user_check && cur.write_req && !entry_data[BIT_W];
  assign lvl_inc      = cur.level + 3'd1;
  assign pa_huge      = {entry_data[51:21], cur.virt[20:0]} & PA_MASK;
  assign pa_page      = {entry_data[51:12], cur.virt[11:0]} & PA_MASK;

  always_comb begin
    nxt = cur;
    res = '0;
    if (kind == KIND_START) begin
      if (cur.level != LVL_IDLE) begin
        res.result_kind    = RK_DONE;
        res.sequence_error = 1'b1;
      end else begin
        nxt.level      = LVL_TOP;
        nxt.virt       = virt_addr;
        nxt.write_req  = write_req;
        nxt.user_check = user_check;
        res.result_kind = RK_READ;
        res.read_addr   = {root_table_base[51:12], level_index(LVL_TOP, virt_addr), 3'b000}
                          & PA_MASK;
      end
    end else if (cur.level == LVL_IDLE) begin
      res.result_kind    = RK_DONE;
      res.sequence_error = 1'b1;
    end else if (!present_ok) begin
      nxt.level       = LVL_IDLE;
      res.result_kind = RK_DONE;
      res.stop_level  = cur.level;
    end else if (is_leaf) begin
      nxt.level       = LVL_IDLE;
      res.result_kind = RK_DONE;
      if (write_denied) begin
        res.stop_level = cur.level;
      end else begin
        res.granted   = 1'b1;
        res.phys_addr = (cur.level == LVL_DIR) ? pa_huge : pa_page;
      end
    end else begin
      nxt.level       = lvl_inc;
      res.result_kind = RK_READ;
      res.read_addr   = {entry_data[51:12], level_index(lvl_inc, cur.virt), 3'b000}
                        & PA_MASK;
    end
  end

endmodule

// ===== rtl/core/four_level_page_walker_core.sv =====
// Four-level page-table walker. Each item is either a walk request (kind 0)
// or a table entry returned from memory (kind 1), and every item gives exactly
// one result: an entry read request or a finished walk with its physical
// address, grant and failing level. The combinational step logic between the
// walk state and the output register feeds a registered result; the block
// accepts one item per cycle while the skid is empty. A two-entry output
// buffer lets one more item in while a result waits to be taken. The APB port
// writes root_table_base at byte addresses 0 to 7 (paddr[3] low).
module four_level_page_walker_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [fplw_pkg::VA_W-1:0]       virt_addr,
  input  logic                            write_req,
  input  logic                            user_check,
  input  logic [fplw_pkg::ENTRY_W-1:0]    entry_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            result_kind,
  output logic [fplw_pkg::PA_W-1:0]       read_addr,
  output logic [fplw_pkg::PA_W-1:0]       phys_addr,
  output logic                            granted,
  output logic [fplw_pkg::LVL_W-1:0]      stop_level,
  output logic                            sequence_error
);
  import fplw_pkg::*;

  logic [PA_W-1:0] root_table_base;
  walk_state_t     walk;
  walk_state_t     walk_next;
  result_t         step_res;
  result_t         out_data;
  result_t         skid_data;
  logic            skid_valid;
  logic            acc;
  logic            take;
  logic            load_out;
  logic            load_skid;
  logic            cfg_wr;

  assign pready   = 1'b1;
  assign prdata   = {{(64-PA_W){1'b0}}, root_table_base};
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[3] == 1'b0);

  assign in_stall = skid_valid;
  assign acc      = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  // a fresh result goes to the output register when it is free, else to skid
  assign load_out  = acc && (!out_valid || take);
  assign load_skid = acc && out_valid && !take;

  fplw_step u_step (
    .cur             (walk),
    .root_table_base (root_table_base),
    .kind            (kind),
    .virt_addr       (virt_addr),
    .write_req       (write_req),
    .user_check      (user_check),
    .entry_data      (entry_data),
    .nxt             (walk_next),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
      walk            <= '0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        root_table_base <= pwdata[PA_W-1:0];
      end
      if (acc) begin
        walk <= walk_next;
      end
      if (take && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (load_out) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_data <= skid_data;
    end else if (load_out) begin
      out_data <= step_res;
    end
    if (load_skid) begin
      skid_data <= step_res;
    end
  end

  assign result_kind    = out_data.result_kind;
  assign read_addr      = out_data.read_addr;
  assign phys_addr      = out_data.phys_addr;
  assign granted        = out_data.granted;
  assign stop_level     = out_data.stop_level;
  assign sequence_error = out_data.sequence_error;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output register is empty");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    walk.level <= LVL_LEAF)
    else $error("walk level out of range");

  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    (acc && kind == KIND_START && walk.level == LVL_IDLE) |=> walk.level == LVL_TOP)
    else $error("accepted request did not start a walk");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == RK_READ) |->
      (!out_data.granted && out_data.phys_addr == '0 && !out_data.sequence_error))
    else $error("read request carries finish fields");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted item produced no result");

endmodule
